[sv/sacw_pkg.sv]
// Shared constants, types and codes for the set-associative write-through cache.
package sacw_pkg;

   localparam int SET_COUNT    = 8;
   localparam int WAY_COUNT    = 4;
   localparam int LINE_BYTES   = 128;
   localparam int MEMORY_BYTES = 64 * 1024;

   localparam int SET_W  = $clog2(SET_COUNT);
   localparam int WAY_W  = $clog2(WAY_COUNT);
   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int ADDR_W = $clog2(MEMORY_BYTES);
   localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
   localparam int SLOT_W = SET_W + WAY_W;
   localparam int LINES  = SET_COUNT * WAY_COUNT;
   localparam int LDAT_W = SLOT_W + OFF_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] AGE_MAX   = 16'hFFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Request kind codes as they arrive on the port.
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Internal operation codes after classification.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        hit;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [TAG_W-1:0] tag;
      logic [SET_W-1:0] set_idx;
      logic [OFF_W-1:0] offset;
      logic [7:0]       wdata;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

[sv/sacw_front.sv]
// Front end: accepts request beats, classifies them and queues them for the back end.
module sacw_front import sacw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req,
   input  logic              pop,
   output logic              head_valid,
   output cmd_type           head,
   output logic [QCNT_W-1:0] count
);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   cmd_type           cmd;
   logic              push;
   logic              take;

   always_comb begin
      cmd.tag     = req.address[ADDR_W-1 -: TAG_W];
      cmd.set_idx = req.address[OFF_W +: SET_W];
      cmd.offset  = req.address[OFF_W-1:0];
      cmd.wdata   = req.write_data;
      case (req.kind)
         KIND_READ:  cmd.op = OP_READ;
         KIND_WRITE: cmd.op = OP_WRITE;
         KIND_FLUSH: cmd.op = OP_FLUSH;
         default:    cmd.op = OP_NONE;
      endcase
   end

   assign req_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign take       = pop && head_valid;
   assign head       = queue_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (take) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !take) count_ff <= count_ff + 1'b1;
         else if (take && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[sv/sacw_back.sv]
// Back end: tag lookup, ages, line fill, backing memory and the result register.
module sacw_back import sacw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  cmd_type         head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp,
   output back_status_type status
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_FILL  = 3'd3;
   localparam logic [2:0] ST_RDHIT = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]        state_ff;
   cmd_type           cmd_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [OFF_W:0]    fill_cnt_ff;
   logic [WAY_W-1:0]  way_ff;
   logic              hit_ff;
   logic [7:0]        rdata_ff;
   logic [31:0]       hits_ff;
   logic [31:0]       misses_ff;
   logic [TAG_W-1:0]  tag_ff   [LINES];
   logic              valid_ff [LINES];
   logic [15:0]       age_ff   [LINES];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [7:0] store_mem [MEMORY_BYTES];
   logic [7:0] line_mem  [LINES * LINE_BYTES];
   logic [7:0] store_rd_ff;
   logic [7:0] line_rd_ff;

   logic [WAY_COUNT-1:0] match;
   logic [15:0]          aged [WAY_COUNT];
   logic                 hit_any;
   logic [WAY_W-1:0]     hit_way;
   logic [WAY_W-1:0]     victim;
   logic [OFF_W-1:0]     fill_prev;

   logic              store_we;
   logic [ADDR_W-1:0] store_waddr;
   logic [7:0]        store_wdata;
   logic [ADDR_W-1:0] store_raddr;
   logic              line_we;
   logic [LDAT_W-1:0] line_waddr;
   logic [7:0]        line_wdata;
   logic [LDAT_W-1:0] line_raddr;
   logic              out_free;

   // Lookup over the ways of the addressed set; ages are compared after the
   // saturating increment so that saturated ties resolve to the lowest way.
   always_comb begin
      logic [SLOT_W-1:0] slot;
      hit_way = '0;
      victim  = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         slot     = {cmd_ff.set_idx, WAY_W'(w)};
         match[w] = valid_ff[slot] && (tag_ff[slot] == cmd_ff.tag);
         aged[w]  = (age_ff[slot] == AGE_MAX) ? AGE_MAX : age_ff[slot] + 16'd1;
      end
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
         if (match[w]) hit_way = WAY_W'(w);
      end
      for (int w = 1; w < WAY_COUNT; w++) begin
         if (aged[w] > aged[victim]) victim = WAY_W'(w);
      end
      hit_any = |match;
   end

   assign fill_prev = fill_cnt_ff[OFF_W-1:0] - 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && head_valid;

   always_comb begin
      store_we    = (state_ff == ST_CLEAR) ||
                    ((state_ff == ST_LOOK) && (cmd_ff.op == OP_WRITE));
      store_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff
                    : {cmd_ff.tag, cmd_ff.set_idx, cmd_ff.offset};
      store_wdata = (state_ff == ST_CLEAR) ? 8'd0 : cmd_ff.wdata;
      store_raddr = {cmd_ff.tag, cmd_ff.set_idx, fill_cnt_ff[OFF_W-1:0]};
      line_we     = ((state_ff == ST_FILL) && (fill_cnt_ff != '0)) ||
                    ((state_ff == ST_LOOK) && (cmd_ff.op == OP_WRITE) && hit_any);
      line_waddr  = (state_ff == ST_FILL) ? {cmd_ff.set_idx, way_ff, fill_prev}
                    : {cmd_ff.set_idx, hit_way, cmd_ff.offset};
      line_wdata  = (state_ff == ST_FILL) ? store_rd_ff : cmd_ff.wdata;
      line_raddr  = {cmd_ff.set_idx, hit_way, cmd_ff.offset};
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_waddr] <= store_wdata;
      store_rd_ff <= store_mem[store_raddr];
      if (line_we) line_mem[line_waddr] <= line_wdata;
      line_rd_ff <= line_mem[line_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         fill_cnt_ff  <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LINES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
            tag_ff[i]   <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (head_valid) begin
                  cmd_ff   <= head;
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               rdata_ff <= 8'd0;
               if ((cmd_ff.op == OP_READ) || (cmd_ff.op == OP_WRITE)) begin
                  hit_ff <= hit_any;
                  // Every way of the set ages; the way that is hit or refilled
                  // starts over from zero.
                  for (int w = 0; w < WAY_COUNT; w++) begin
                     if (hit_any ? (hit_way == WAY_W'(w))
                                 : ((cmd_ff.op == OP_READ) && (victim == WAY_W'(w)))) begin
                        age_ff[{cmd_ff.set_idx, WAY_W'(w)}] <= '0;
                     end else begin
                        age_ff[{cmd_ff.set_idx, WAY_W'(w)}] <= aged[w];
                     end
                  end
                  if (hit_any) begin
                     if (hits_ff != COUNT_MAX) hits_ff <= hits_ff + 32'd1;
                  end else begin
                     if (misses_ff != COUNT_MAX) misses_ff <= misses_ff + 32'd1;
                  end
                  if ((cmd_ff.op == OP_READ) && hit_any) begin
                     state_ff <= ST_RDHIT;
                  end else if (cmd_ff.op == OP_READ) begin
                     valid_ff[{cmd_ff.set_idx, victim}] <= 1'b1;
                     tag_ff[{cmd_ff.set_idx, victim}]   <= cmd_ff.tag;
                     way_ff      <= victim;
                     fill_cnt_ff <= '0;
                     state_ff    <= ST_FILL;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  hit_ff   <= 1'b0;
                  state_ff <= ST_DONE;
                  if (cmd_ff.op == OP_FLUSH) begin
                     hits_ff    <= '0;
                     misses_ff  <= '0;
                     clr_cnt_ff <= '0;
                     for (int i = 0; i < LINES; i++) begin
                        valid_ff[i] <= 1'b0;
                        age_ff[i]   <= '0;
                        tag_ff[i]   <= '0;
                     end
                  end
               end
            end
            ST_FILL: begin
               fill_cnt_ff <= fill_cnt_ff + 1'b1;
               if ((fill_cnt_ff != '0) && (fill_prev == cmd_ff.offset)) begin
                  rdata_ff <= store_rd_ff;
               end
               if (fill_cnt_ff == (OFF_W+1)'(LINE_BYTES)) state_ff <= ST_DONE;
            end
            ST_RDHIT: begin
               rdata_ff <= line_rd_ff;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{read_data: rdata_ff, hit: hit_ff,
                                    hit_total: hits_ff, miss_total: misses_ff};
                  state_ff     <= (cmd_ff.op == OP_FLUSH) ? ST_CLEAR : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_IDLE);

endmodule

[sv/set_assoc_cache_write_through_top.sv]
// Top level of the 4-way, 8-set write-through, no-write-allocate byte cache.
// Each request beat is a byte read, a byte write or a flush of memory, cache and
// counts; each gives exactly one response beat with the byte read, the hit flag
// and the saturating hit and miss totals. After reset, and after every flush, the
// 64 KB backing memory is swept to zero one byte a cycle, and the block serves no
// request until that sweep is over (the flush response itself is sent before that
// sweep). A front end decodes requests into a two-entry queue, so up to two beats
// are taken while the back end is busy. In the back end a write, or a request of
// the unused kind, goes from the lookup to the result; a read hit also passes the
// registered read of the line memory; a read miss first fills the whole line, which
// moves one byte per cycle through the single read port of the backing memory.
// A response waits in an output register until it is taken, and the back end
// moves on to the next queued request as soon as that register is free.
module set_assoc_cache_write_through_top import sacw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic              head_valid;
   cmd_type           head;
   logic              pop;
   logic [QCNT_W-1:0] q_count;
   back_status_type   status;

   sacw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .count      (q_count)
   );

   sacw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp),
      .status     (status)
   );

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("request queue overfilled");

   // No request leaves the queue while the memory sweep runs.
   assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !pop)
      else $error("request taken during memory sweep");

   // A hit beat always carries a nonzero hit total.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.hit) |-> (rsp.hit_total != 32'd0))
      else $error("hit reported with zero hit total");

endmodule

[bench/cache_checker.sv]
// Checker that predicts the write-through cache responses and compares them.
module cache_checker import sacw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp,
   output int      error_count,
   output int      pending_count
);

   logic [7:0]       mem_bytes [MEMORY_BYTES];
   logic [7:0]       cached_bytes [LINES][LINE_BYTES];
   logic [TAG_W-1:0] way_tag [LINES];
   logic             way_valid [LINES];
   logic [15:0]      way_age [LINES];
   logic [31:0]      hit_tally;
   logic [31:0]      miss_tally;
   rsp_type          expected_rsp [$];

   function automatic void clear_cache();
      for (int i = 0; i < MEMORY_BYTES; i++) mem_bytes[i] = 8'd0;
      for (int s = 0; s < LINES; s++) begin
         for (int b = 0; b < LINE_BYTES; b++) cached_bytes[s][b] = 8'd0;
         way_tag[s] = '0;
         way_valid[s] = 1'b0;
         way_age[s] = 16'd0;
      end
      hit_tally = '0;
      miss_tally = '0;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type          res;
      int               set_idx, base, slot, way, best;
      logic [TAG_W-1:0] tag;
      int               offset;
      res = '0;
      set_idx = (r.address / LINE_BYTES) % SET_COUNT;
      tag = TAG_W'(r.address / (LINE_BYTES * SET_COUNT));
      offset = r.address % LINE_BYTES;
      if (r.kind == KIND_READ || r.kind == KIND_WRITE) begin
         way = WAY_COUNT;
         for (int w = WAY_COUNT - 1; w >= 0; w--)
            if (way_valid[set_idx*WAY_COUNT+w] && way_tag[set_idx*WAY_COUNT+w] == tag)
               way = w;
         res.hit = (way < WAY_COUNT);
         for (int w = 0; w < WAY_COUNT; w++)
            if (way_age[set_idx*WAY_COUNT+w] != AGE_MAX)
               way_age[set_idx*WAY_COUNT+w]++;
         if (r.kind == KIND_READ) begin
            if (!res.hit) begin
               best = 0;
               for (int w = 1; w < WAY_COUNT; w++)
                  if (way_age[set_idx*WAY_COUNT+w] > way_age[set_idx*WAY_COUNT+best])
                     best = w;
               way = best;
               slot = set_idx * WAY_COUNT + way;
               base = (r.address / LINE_BYTES) * LINE_BYTES;
               for (int b = 0; b < LINE_BYTES; b++)
                  cached_bytes[slot][b] = mem_bytes[base + b];
               way_valid[slot] = 1'b1;
               way_tag[slot] = tag;
            end
            slot = set_idx * WAY_COUNT + way;
            way_age[slot] = 16'd0;
            res.read_data = cached_bytes[slot][offset];
         end else begin
            mem_bytes[r.address] = r.write_data;
            if (res.hit) begin
               slot = set_idx * WAY_COUNT + way;
               cached_bytes[slot][offset] = r.write_data;
               way_age[slot] = 16'd0;
            end
         end
         if (res.hit) begin
            if (hit_tally != COUNT_MAX) hit_tally++;
         end else if (miss_tally != COUNT_MAX) begin
            miss_tally++;
         end
      end else if (r.kind == KIND_FLUSH) begin
         clear_cache();
      end
      res.hit_total = hit_tally;
      res.miss_total = miss_tally;
      return res;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_cache();
         expected_rsp.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsp.push_back(predict_access(req));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, rsp);
               error_count <= error_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp !== want) begin
                  $display("%0t: mismatch expected data=%h hit=%b hits=%0d misses=%0d",
                     $time, want.read_data, want.hit, want.hit_total, want.miss_total);
                  $display("%0t:          actual   data=%h hit=%b hits=%0d misses=%0d",
                     $time, rsp.read_data, rsp.hit, rsp.hit_total, rsp.miss_total);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

[bench/set_assoc_cache_write_through_top_tb.sv]
// Stimulus and verdict for the write-through cache testbench.
module set_assoc_cache_write_through_top_tb;
   import sacw_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;
   int      error_count;
   int      pending_count;
   // Once set, neither side idles any more, so the tail runs at full rate.
   logic    steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   set_assoc_cache_write_through_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
   );

   cache_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .error_count(error_count), .pending_count(pending_count)
   );

   // Addresses are drawn at random for reads and writes alike; memory is swept
   // to zero after reset and each flush, so every read is well defined either way.
   // Tags are drawn from a small pool so that sets overflow their four ways
   // and evictions happen often.
   function automatic logic [15:0] pick_address();
      logic [15:0] a;
      a = 16'($urandom);
      case ($urandom_range(0, 3))
         0: a[15:10] = 6'($urandom_range(0, 5));
         1: a[15:10] = 6'h3F - 6'($urandom_range(0, 1));
         default: a[15:10] = 6'($urandom_range(0, 7));
      endcase
      return a;
   endfunction

   // Sends one beat: the payload changes on a falling edge and is held until
   // the beat is taken at a rising edge. An idle burst may come first.
   // Valid stays high into the next beat when there is no idle burst.
   task automatic send_beat(logic [1:0] kind, logic [15:0] address, logic [7:0] data);
      logic taken;
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req.kind <= kind;
      req.address <= address;
      req.write_data <= data;
      // Ready only moves at a rising edge, so the value seen at the falling
      // edge is the one that the next rising edge uses.
      do begin
         taken = req_ready;
         @(posedge clock);
         if (!taken) @(negedge clock);
      end while (!taken);
      @(negedge clock);
   endtask

   // The response side stalls in random bursts until the tail of the run.
   initial begin
      @(negedge clock);
      while (1) begin
         if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   initial begin
      logic [15:0] a;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: address extremes, all kinds, the unused kind, a hit
      // after a fill, five lines in one set to force an eviction, a write
      // hit and a write miss, and a flush that clears everything.
      send_beat(KIND_WRITE, 16'h0000, 8'hFF);
      send_beat(KIND_READ, 16'h0000, 8'h00);
      send_beat(KIND_READ, 16'h0000, 8'h00);
      send_beat(KIND_WRITE, 16'hFFFF, 8'hA5);
      send_beat(KIND_READ, 16'hFFFF, 8'h00);
      send_beat(KIND_WRITE, 16'hFFFF, 8'h5A);
      send_beat(KIND_READ, 16'hFFFF, 8'h00);
      send_beat(KIND_UNUSED, 16'hFFFF, 8'hFF);
      for (int t = 0; t < 5; t++) send_beat(KIND_READ, {t[5:0], 10'h005}, 8'h00);
      send_beat(KIND_READ, 16'h0005, 8'h00);
      send_beat(KIND_WRITE, 16'h2405, 8'h11);
      send_beat(KIND_READ, 16'h2405, 8'h00);
      send_beat(KIND_FLUSH, 16'h0000, 8'h00);
      send_beat(KIND_READ, 16'h0000, 8'h00);
      send_beat(KIND_READ, 16'hFFFF, 8'h00);

      // Random part: mostly reads and writes over a few tags, rare flushes
      // and the odd unused kind.
      for (int n = 0; n < 500; n++) begin
         if (n == 420) steady = 1'b1;
         a = pick_address();
         case ($urandom_range(0, 99))
            0: send_beat(KIND_FLUSH, a, 8'($urandom));
            1, 2: send_beat(KIND_UNUSED, a, 8'($urandom));
            default: send_beat($urandom_range(0, 1) ? KIND_READ : KIND_WRITE, a,
                               8'($urandom));
         endcase
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Worst case: every beat a read miss with long stalls, plus a memory sweep
   // after reset and after each flush.
   initial begin
      #60000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
